>>> design/char_lcd_shadow_buffer_assert.svh
// Assertion macros used by the checker file of the LCD shadow buffer.
`ifndef CHAR_LCD_SHADOW_BUFFER_ASSERT_SVH
`define CHAR_LCD_SHADOW_BUFFER_ASSERT_SVH

// Clocked assertion, muted while reset is high.
`define CLSB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CLSB_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/clsb_pkg.sv
// Shared constants, types and request codes of the LCD shadow buffer.
`default_nettype none

package clsb_pkg;

   localparam int ROWS       = 2;
   localparam int COLS       = 16;
   localparam int MAX_DIGITS = 7;

   localparam int DEPTH  = ROWS * COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CUR_W  = $clog2(COLS + 1);
   localparam int DIG_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int BCD_W  = 4 * MAX_DIGITS;

   // number field and its saturated magnitude
   localparam int          NUM_W   = 25;
   localparam longint      LIMIT   = (64'd10 ** MAX_DIGITS) - 64'd1;
   localparam int          LIM_W   = $clog2(LIMIT + 64'd1);
   localparam int          MAG_W   = (LIM_W < NUM_W) ? LIM_W : NUM_W;
   localparam int          CNT_W   = $clog2(MAG_W + 1);

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] ADDR_MASK    = 8'h7F;
   localparam logic [7:0] ROW_ODD_BASE = 8'h40;

   typedef enum logic [2:0] {
      REQ_SET_CURSOR = 3'd0,
      REQ_PUT_CHAR   = 3'd1,
      REQ_WRITE_NUM  = 3'd2,
      REQ_CLEAR      = 3'd3,
      REQ_REFRESH    = 3'd4
   } clsb_req_code_type;

   // one write into the screen memory
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } clsb_wr_type;

endpackage

`default_nettype wire

>>> design/clsb_ifs.sv
// Request and response channel interfaces of the LCD shadow buffer.
`default_nettype none

interface clsb_req_if import clsb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [2:0]              req_type;
   logic                    row;
   logic [3:0]              column;
   logic [7:0]              char_code;
   logic signed [NUM_W-1:0] number;

   modport source (output valid, output req_type, output row, output column,
                   output char_code, output number, input ready);
   modport sink   (input valid, input req_type, input row, input column,
                   input char_code, input number, output ready);
endinterface

interface clsb_rsp_if ();
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic [7:0] bus_byte;
   logic       last;

   modport source (output valid, output reg_select, output bus_byte, output last,
                   input ready);
   modport sink   (input valid, input reg_select, input bus_byte, input last,
                   output ready);
endinterface

`default_nettype wire

>>> design/clsb_screen_ram.sv
// Character memory with per-entry valid bits; unwritten entries read as space.
`default_nettype none

module clsb_screen_ram import clsb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire clsb_wr_type       wr,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : CHAR_SPACE;

endmodule

`default_nettype wire

>>> design/clsb_digits.sv
// Binary to BCD converter (shift and add-3), one magnitude bit per cycle.
`default_nettype none

module clsb_digits import clsb_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [NUM_W-1:0] number,
   output logic                         done,
   input  wire logic [DIG_W-1:0]        digit_sel,
   output logic [3:0]                   digit
);

   logic [NUM_W-1:0] mag_raw;
   logic [MAG_W-1:0] mag_sat;
   logic [BCD_W-1:0] bcd_adj;

   logic [MAG_W-1:0] shift_ff, shift_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      // two's complement magnitude, then clamp to the printable limit
      mag_raw = number[NUM_W-1] ? (~number + NUM_W'(1)) : number;
      if (64'(mag_raw) > LIMIT) begin
         mag_sat = MAG_W'(LIMIT);
      end else begin
         mag_sat = MAG_W'(mag_raw);
      end

      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end

      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = mag_sat;
         bcd_in   = '0;
         cnt_in   = CNT_W'(MAG_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = {bcd_adj[BCD_W-2:0], shift_ff[MAG_W-1]};
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign digit = bcd_ff[4*digit_sel +: 4];

endmodule

`default_nettype wire

>>> design/char_lcd_shadow_buffer.sv
// Top level of the character LCD shadow buffer: request decode, sequencer, refresh stream.
//
//   channel   dir  beat                                       accepted when
//   req_bus   in   req_type, row, column, char_code, number   valid & ready
//   rsp_bus   out  reg_select, bus_byte, last                 valid & ready
//
// Cursor, put char and clear are carried out on acceptance; req_bus.ready is high in IDLE.
// Write number: take the request, run the BCD converter until its done flag, write the
// sign in ST_SIGN, then walk the MAX_DIGITS (7) digit places in ST_DIGIT.
// Refresh: ROWS*(COLS+1) = 34 beats, one per cycle unless rsp_bus stalls; cell beats read
// the screen memory; beats pass stage 1 and the output register; stalls hold the stream.
// Synchronous reset marks every cell as space and homes the cursor.
`default_nettype none

module char_lcd_shadow_buffer import clsb_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   clsb_req_if.sink    req_bus,
   clsb_rsp_if.source  rsp_bus
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_CONV    = 5'b00010,
      ST_SIGN    = 5'b00100,
      ST_DIGIT   = 5'b01000,
      ST_REFRESH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;

   // cursor; column may rest at COLS after the row is full
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [CUR_W-1:0] cur_col_ff, cur_col_in;

   // number printing
   logic             neg_ff, neg_in;
   logic [DIG_W-1:0] dig_idx_ff, dig_idx_in;
   logic             started_ff, started_in;

   // refresh walk: pos 0 is the set-address command, 1..COLS the cells
   logic [ROW_W-1:0] rf_row_ff, rf_row_in;
   logic [CUR_W-1:0] rf_pos_ff, rf_pos_in;
   logic             rf_done_ff, rf_done_in;

   // stage 1: beat waiting on the memory read register
   logic             p1_valid_ff, p1_valid_in;
   logic             p1_cmd_ff, p1_cmd_in;
   logic [7:0]       p1_byte_ff, p1_byte_in;
   logic             p1_last_ff, p1_last_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_rs_ff, rsp_rs_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              advance;
   logic              put_en;
   logic [7:0]        put_char;
   logic              conv_start;
   logic              conv_done;
   logic [3:0]        digit;
   logic              clear;
   clsb_wr_type       wr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [ROW_W-1:0]  row_m;
   logic [CUR_W-1:0]  col_m;
   logic [7:0]        cmd_addr;

   clsb_screen_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   clsb_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .number    (req_bus.number),
      .done      (conv_done),
      .digit_sel (dig_idx_ff),
      .digit     (digit)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign advance       = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      // row and column folded into range
      row_m = (ROWS == 1) ? '0 : ROW_W'(req_bus.row);
      if (32'(req_bus.column) >= COLS) begin
         col_m = CUR_W'(32'(req_bus.column) - COLS);
      end else begin
         col_m = CUR_W'(req_bus.column);
      end
      // DDRAM row start: odd rows at 0x40, row pairs stacked by COLS
      cmd_addr = (rf_row_ff[0] ? ROW_ODD_BASE : 8'h00)
               + 8'(32'(rf_row_ff >> 1) * COLS);
   end

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      neg_in       = neg_ff;
      dig_idx_in   = dig_idx_ff;
      started_in   = started_ff;
      rf_row_in    = rf_row_ff;
      rf_pos_in    = rf_pos_ff;
      rf_done_in   = rf_done_ff;
      p1_valid_in  = p1_valid_ff;
      p1_cmd_in    = p1_cmd_ff;
      p1_byte_in   = p1_byte_ff;
      p1_last_in   = p1_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rs_in    = rsp_rs_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      put_en       = 1'b0;
      put_char     = CHAR_SPACE;
      conv_start   = 1'b0;
      clear        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr           = '0;

      // output register takes stage 1 when free or drained
      if (advance) begin
         rsp_valid_in = p1_valid_ff;
         if (p1_valid_ff) begin
            rsp_rs_in   = !p1_cmd_ff;
            rsp_byte_in = p1_cmd_ff ? p1_byte_ff : rd_data;
            rsp_last_in = p1_last_ff;
         end
         p1_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_bus.req_type)
                  REQ_SET_CURSOR: begin
                     cur_row_in = row_m;
                     cur_col_in = col_m;
                  end
                  REQ_PUT_CHAR: begin
                     put_en   = 1'b1;
                     put_char = req_bus.char_code;
                  end
                  REQ_WRITE_NUM: begin
                     cur_row_in = row_m;
                     cur_col_in = col_m;
                     neg_in     = req_bus.number[NUM_W-1];
                     conv_start = 1'b1;
                     state_in   = ST_CONV;
                  end
                  REQ_CLEAR: begin
                     clear = 1'b1;
                  end
                  REQ_REFRESH: begin
                     rf_row_in  = '0;
                     rf_pos_in  = '0;
                     rf_done_in = 1'b0;
                     state_in   = ST_REFRESH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            // a negative value is never zero, so the sign always precedes digits
            put_en     = neg_ff;
            put_char   = CHAR_MINUS;
            dig_idx_in = DIG_W'(MAX_DIGITS - 1);
            started_in = 1'b0;
            state_in   = ST_DIGIT;
         end
         ST_DIGIT: begin
            // leading zeros dropped; the units digit always prints (zero case)
            if (digit != 4'd0 || started_ff || dig_idx_ff == '0) begin
               put_en     = 1'b1;
               put_char   = CHAR_ZERO + {4'd0, digit};
               started_in = 1'b1;
            end
            if (dig_idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               dig_idx_in = dig_idx_ff - DIG_W'(1);
            end
         end
         ST_REFRESH: begin
            if (!rf_done_ff && (!p1_valid_ff || advance)) begin
               p1_valid_in = 1'b1;
               p1_cmd_in   = (rf_pos_ff == '0);
               p1_byte_in  = CMD_SET_ADDR | (cmd_addr & ADDR_MASK);
               p1_last_in  = (rf_row_ff == ROW_W'(ROWS - 1))
                           && (rf_pos_ff == CUR_W'(COLS));
               if (rf_pos_ff != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(32'(rf_row_ff) * COLS + 32'(rf_pos_ff) - 1);
               end
               if (rf_pos_ff == CUR_W'(COLS)) begin
                  rf_pos_in = '0;
                  if (rf_row_ff == ROW_W'(ROWS - 1)) begin
                     rf_done_in = 1'b1;
                  end else begin
                     rf_row_in = rf_row_ff + ROW_W'(1);
                  end
               end else begin
                  rf_pos_in = rf_pos_ff + CUR_W'(1);
               end
            end
            if (rf_done_ff && !p1_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // store at the cursor and advance; past the row end the char is dropped
      if (put_en && cur_col_ff < CUR_W'(COLS)) begin
         wr.en      = 1'b1;
         wr.addr    = ADDR_W'(32'(cur_row_ff) * COLS + 32'(cur_col_ff));
         wr.data    = put_char;
         cur_col_in = cur_col_ff + CUR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      neg_in_reg: begin
         neg_ff      <= neg_in;
         dig_idx_ff  <= dig_idx_in;
         started_ff  <= started_in;
         rf_row_ff   <= rf_row_in;
         rf_pos_ff   <= rf_pos_in;
         p1_cmd_ff   <= p1_cmd_in;
         p1_byte_ff  <= p1_byte_in;
         p1_last_ff  <= p1_last_in;
         rsp_rs_ff   <= rsp_rs_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         rf_done_ff   <= 1'b1;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         rf_done_ff   <= rf_done_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.reg_select = rsp_rs_ff;
   assign rsp_bus.bus_byte   = rsp_byte_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule

`default_nettype wire

>>> design/clsb_checker.sv
// Port-level checker of the LCD shadow buffer, bound to the top level.
`default_nettype none

`include "char_lcd_shadow_buffer_assert.svh"

module clsb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_reg_select,
   input wire logic [7:0] rsp_bus_byte,
   input wire logic       rsp_last
);

   // a stalled beat holds
   `CLSB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_byte) && $stable(rsp_reg_select) && $stable(rsp_last), "rsp beat changed while stalled")

   // the closing beat of a refresh is a data byte
   `CLSB_ASSERT(a_last_is_data, rsp_valid && rsp_last |-> rsp_reg_select, "last set on a command beat")

   // every command beat is a set-address command
   `CLSB_ASSERT(a_cmd_set_addr, rsp_valid && !rsp_reg_select |-> rsp_bus_byte[7] && !rsp_last, "bad command beat")

   // reset empties the output register and opens the request side
   `CLSB_ASSERT_RST(a_reset_state, reset |=> !rsp_valid && req_ready, "output not empty after reset")

endmodule

bind char_lcd_shadow_buffer clsb_checker u_clsb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_reg_select (rsp_bus.reg_select),
   .rsp_bus_byte   (rsp_bus.bus_byte),
   .rsp_last       (rsp_bus.last)
);

`default_nettype wire
